@@ src/tpi_pkg.sv @@
`default_nettype none
package tpi_pkg;

	localparam int BUFFER_DEPTH_DEF = 256;

	localparam int STAMP_W = 48;
	localparam int POS_W   = 32;
	localparam int HEAD_W  = 16;
	localparam int WIN_W   = 26;
	localparam int TOL_W   = 20;
	localparam int RATIO_W = 17;

	localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(5000000);
	localparam logic [TOL_W-1:0] TOL_RST    = TOL_W'(100000);

	// register index, decoded from paddr[2]
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_TOL    = 1'b1;

	localparam logic ACT_PUSH   = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef struct packed {
		logic [HEAD_W-1:0]  heading;
		logic [POS_W-1:0]   pos_y;
		logic [POS_W-1:0]   pos_x;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

endpackage
`default_nettype wire

@@ src/timestamped_pose_interpolator_unit.sv @@
// Push: writes the entry, then prunes entries older than the window (one ring read per check).
// Lookup: an empty ring gives a miss at once; at the buffer ends the end sample is checked against tol;
// between samples the ring is walked, then a serial divide forms the 17-bit ratio for one shared multiplier.
// The walk over the one-read-port sample ring sets the worst case, which output stalls can lengthen.
// One item at a time; s_tready is low from accept until pruning ends (push) or the result is registered (lookup).
// Reset (arst_n low, asynchronous) empties the ring and loads register defaults.
`default_nettype none
module timestamped_pose_interpolator_unit #(
	parameter int BUFFER_DEPTH = tpi_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // stamp[47:0], pos_x, pos_y, heading
	input  wire logic         s_tuser,   // action
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [79:0]       m_tdata,   // out_x[31:0], out_y, out_heading
	output logic              m_tuser,   // found
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import tpi_pkg::*;

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(BUFFER_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PUSH, ST_WAIT, ST_PRUNE, ST_FRONT, ST_BACK, ST_WALK,
		ST_DIV, ST_MUL, ST_EMIT
	} state_t;

	function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW+1)'(BUFFER_DEPTH))
			s = s - (AW+1)'(BUFFER_DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
		return (a == LAST_SLOT) ? '0 : a + AW'(1);
	endfunction

	state_t state_q, ret_q;
	logic [WIN_W-1:0] window_q;
	logic [TOL_W-1:0] tol_q;
	logic [AW-1:0] oldest_q, ptr_q;
	logic [CW-1:0] fill_q, k_q;
	entry_t in_q, prev_q, newer_q, rd_q;
	logic [STAMP_W:0] rem_q, dt_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [4:0] step_q;
	logic [1:0] mi_q;
	logic signed [POS_W+RATIO_W+1:0] prod_q;
	logic res_found_q;
	logic [POS_W-1:0] res_x_q, res_y_q;
	logic [HEAD_W-1:0] res_h_q;

	entry_t mem [BUFFER_DEPTH];

	// push slot selection
	logic full;
	logic [AW-1:0] base_slot, wr_slot;
	logic [CW-1:0] base_cnt;
	logic we;

	assign full      = (fill_q == FULL_CNT);
	assign base_slot = full ? slot_inc(oldest_q) : oldest_q;
	assign base_cnt  = full ? FULL_CNT - CW'(1) : fill_q;
	assign wr_slot   = slot_add(base_slot, base_cnt[AW-1:0]);
	assign we        = (state_q == ST_PUSH);

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_slot] <= in_q;
		rd_q <= mem[ptr_q];
	end

	// compare-subtract unit of the divider
	logic [STAMP_W+1:0] trial;
	logic [STAMP_W:0] shifted;
	assign shifted = (step_q == '0) ? rem_q : {rem_q[STAMP_W-1:0], 1'b0};
	assign trial   = {1'b0, shifted} - {1'b0, dt_q};

	// shared multiplier operand
	logic signed [POS_W:0] dx, dy, mop;
	logic [HEAD_W-1:0] dh;
	assign dx = $signed({newer_q.pos_x[POS_W-1], newer_q.pos_x})
		- $signed({prev_q.pos_x[POS_W-1], prev_q.pos_x});
	assign dy = $signed({newer_q.pos_y[POS_W-1], newer_q.pos_y})
		- $signed({prev_q.pos_y[POS_W-1], prev_q.pos_y});
	assign dh = newer_q.heading - prev_q.heading;
	always_comb begin
		case (mi_q)
			2'd0:    mop = dx;
			2'd1:    mop = dy;
			default: mop = $signed({{(POS_W+1-HEAD_W){dh[HEAD_W-1]}}, dh});
		endcase
	end

	logic signed [POS_W+RATIO_W+1:0] rnd;
	assign rnd = (prod_q + (POS_W+RATIO_W+2)'(32768)) >>> 16;

	logic [STAMP_W-1:0] tgt, rt;
	assign tgt = in_q.stamp;
	assign rt  = rd_q.stamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			window_q    <= WINDOW_RST;
			tol_q       <= TOL_RST;
			oldest_q    <= '0;
			fill_q      <= '0;
			ptr_q       <= '0;
			k_q         <= '0;
			step_q      <= '0;
			mi_q        <= '0;
			m_tvalid    <= 1'b0;
			res_found_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				unique case (paddr[2])
					REG_WINDOW: window_q <= pwdata[WIN_W-1:0];
					REG_TOL:    tol_q <= pwdata[TOL_W-1:0];
					default: ;
				endcase
			end
			// the emit state drives valid itself when the result is taken
			if (m_tvalid && m_tready && state_q != ST_EMIT)
				m_tvalid <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						in_q <= s_tdata;
						if (s_tuser == ACT_PUSH) begin
							state_q <= ST_PUSH;
						end else if (fill_q == '0) begin
							res_found_q <= 1'b0;
							state_q     <= ST_EMIT;
						end else begin
							ptr_q   <= oldest_q;
							ret_q   <= ST_FRONT;
							state_q <= ST_WAIT;
						end
					end
				end
				ST_PUSH: begin
					oldest_q <= base_slot;
					fill_q   <= base_cnt + CW'(1);
					ptr_q    <= base_slot;
					ret_q    <= ST_PRUNE;
					state_q  <= ST_WAIT;
				end
				ST_WAIT: state_q <= ret_q;
				ST_PRUNE: begin
					if (fill_q != '0 && rt < tgt
							&& (tgt - rt) > STAMP_W'(window_q)) begin
						oldest_q <= slot_inc(oldest_q);
						ptr_q    <= slot_inc(oldest_q);
						fill_q   <= fill_q - CW'(1);
						state_q  <= ST_WAIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FRONT: begin
					prev_q <= rd_q;
					if (tgt <= rt) begin
						res_found_q <= (rt - tgt) <= STAMP_W'(tol_q);
						newer_q     <= rd_q;
						state_q     <= ST_EMIT;
					end else begin
						ptr_q   <= slot_add(oldest_q, AW'(fill_q - CW'(1)));
						ret_q   <= ST_BACK;
						state_q <= ST_WAIT;
					end
				end
				ST_BACK: begin
					if (tgt >= rt) begin
						res_found_q <= (tgt - rt) <= STAMP_W'(tol_q);
						newer_q     <= rd_q;
						state_q     <= ST_EMIT;
					end else begin
						k_q     <= CW'(1);
						ptr_q   <= slot_inc(oldest_q);
						ret_q   <= ST_WALK;
						state_q <= ST_WAIT;
					end
				end
				ST_WALK: begin
					if (tgt > rt) begin
						prev_q <= rd_q;
						k_q    <= k_q + CW'(1);
						if (k_q + CW'(1) >= fill_q) begin
							res_found_q <= 1'b0;
							state_q     <= ST_EMIT;
						end else begin
							ptr_q   <= slot_inc(ptr_q);
							state_q <= ST_WAIT;
						end
					end else if (rt <= prev_q.stamp || tgt <= prev_q.stamp) begin
						res_found_q <= 1'b1;
						newer_q     <= rd_q;
						state_q     <= ST_EMIT;
					end else begin
						newer_q <= rd_q;
						dt_q    <= {1'b0, rt - prev_q.stamp};
						rem_q   <= {1'b0, tgt - prev_q.stamp};
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!trial[STAMP_W+1]) begin
						rem_q   <= trial[STAMP_W:0];
						ratio_q <= {ratio_q[RATIO_W-2:0], 1'b1};
					end else begin
						rem_q   <= shifted;
						ratio_q <= {ratio_q[RATIO_W-2:0], 1'b0};
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'(RATIO_W - 1)) begin
						mi_q    <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mi_q != 2'd3)
						prod_q <= mop * $signed({1'b0, ratio_q});
					case (mi_q)
						2'd1: res_x_q <= prev_q.pos_x + rnd[POS_W-1:0];
						2'd2: res_y_q <= prev_q.pos_y + rnd[POS_W-1:0];
						2'd3: res_h_q <= prev_q.heading + rnd[HEAD_W-1:0];
						default: ;
					endcase
					mi_q <= mi_q + 2'd1;
					if (mi_q == 2'd3) begin
						res_found_q <= 1'b1;
						newer_q     <= '0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tuser  <= res_found_q;
						if (!res_found_q)
							m_tdata <= '0;
						else if (ret_q == ST_WALK && mi_q == 2'd0 && newer_q == '0)
							m_tdata <= {res_h_q, res_y_q, res_x_q};
						else
							m_tdata <= {newer_q.heading, newer_q.pos_y, newer_q.pos_x};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_TOL) ? 32'(tol_q) : 32'(window_q);

endmodule
`default_nettype wire

@@ src/tpi_checker.sv @@
`default_nettype none
module tpi_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        pready
);
	import tpi_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss carries nonzero pose");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind timestamped_pose_interpolator_unit tpi_checker u_tpi_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
	.pready(pready)
);
`default_nettype wire
